### rtl/core/bft_pkg.sv
// ----------------------------------------------------------------------------
// Bigram frequency table package
// Word formats, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bft_pkg;

    // operation codes carried in the kind field
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_FIND  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key;
        logic [31:0] amount;
        logic [7:0]  index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  position;
        logic [15:0] entry_key;
        logic [31:0] frequency;
        logic [8:0]  fill_count;
    } out_word_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_RD_ISSUE,
        FSM_RD_LATCH,
        FSM_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic load_in;
        logic scan_step;
        logic rd_issue;
        logic rd_latch;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] new_kind;
        logic       scan_done;
        logic       out_free;
    } dp_sts_t;

endpackage

### rtl/core/bft_ctrl.sv
// ----------------------------------------------------------------------------
// Bigram frequency table controller
// Sequences one word at a time: table scan, indexed read or neither (clear),
// then the update and result load.
// ----------------------------------------------------------------------------
module bft_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output bft_pkg::dp_cmd_t cmd,
    input  bft_pkg::dp_sts_t sts
);
    import bft_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    unique case (sts.new_kind)
                        KIND_ADD, KIND_FIND: state_next = FSM_SCAN;
                        KIND_READ:           state_next = FSM_RD_ISSUE;
                        default:             state_next = FSM_FINISH;
                    endcase
                end
            end
            FSM_SCAN: begin
                if (sts.scan_done) begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_RD_ISSUE: state_next = FSM_RD_LATCH;
            FSM_RD_LATCH: state_next = FSM_FINISH;
            FSM_FINISH: begin
                if (sts.out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == FSM_IDLE);
        cmd.load_in   = (state_reg == FSM_IDLE) && s_valid;
        cmd.scan_step = (state_reg == FSM_SCAN);
        cmd.rd_issue  = (state_reg == FSM_RD_ISSUE);
        cmd.rd_latch  = (state_reg == FSM_RD_LATCH);
        // hold the result until the output register can take it
        cmd.finish    = (state_reg == FSM_FINISH) && sts.out_free;
    end

endmodule

### rtl/core/bft_dpath.sv
// ----------------------------------------------------------------------------
// Bigram frequency table datapath
// Key and count memories, scan pointer, fill count, saturating update and
// the output register.
// ----------------------------------------------------------------------------
module bft_dpath #(
    parameter int ENTRIES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bft_pkg::in_word_t  s_data,
    output bft_pkg::out_word_t m_data,
    output logic               m_valid,
    input  logic               m_ready,
    input  bft_pkg::dp_cmd_t   cmd,
    output bft_pkg::dp_sts_t   sts
);
    import bft_pkg::*;

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [15:0] key_mem [ENTRIES];
    logic [31:0] cnt_mem [ENTRIES];

    in_word_t    in_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic        rdv_reg;
    logic        found_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [15:0] rd_key_reg;
    logic [31:0] rd_cnt_reg;
    logic [AW-1:0] hold_pos_reg;
    logic [15:0] hold_key_reg;
    logic [31:0] hold_cnt_reg;
    out_word_t   out_reg;
    out_word_t   out_next;
    logic        m_valid_reg;

    logic        ptr_in_range;
    logic [31:0] idx_ext;
    logic [31:0] used_ext;
    logic        idx_ok;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        key_match;
    logic        full;
    logic [32:0] sum;
    logic [31:0] sat_sum;
    logic        key_we;
    logic        cnt_we;
    logic [AW-1:0] wr_addr;
    logic [31:0] cnt_wdata;
    logic [AW-1:0] pos_sel;
    logic [31:0] pos_ext;
    logic [31:0] fill_ext;

    assign ptr_in_range = ptr_reg < used_reg;
    assign idx_ext      = 32'(in_reg.index);
    assign used_ext     = 32'(used_reg);
    assign idx_ok       = idx_ext < used_ext;
    assign rd_en        = (cmd.scan_step && ptr_in_range) || (cmd.rd_issue && idx_ok);
    assign rd_addr      = cmd.scan_step ? ptr_reg[AW-1:0] : idx_ext[AW-1:0];
    assign key_match    = rdv_reg && (rd_key_reg == in_reg.key);
    assign full         = (used_reg == CNT_W'(ENTRIES));
    assign sum          = {1'b0, hold_cnt_reg} + {1'b0, in_reg.amount};
    assign sat_sum      = sum[32] ? '1 : sum[31:0];

    assign sts.new_kind  = s_data.kind;
    // done on a match, or once the last issued read has been compared
    assign sts.scan_done = key_match || (!rdv_reg && !ptr_in_range);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        used_next = used_reg;
        key_we    = 1'b0;
        cnt_we    = 1'b0;
        wr_addr   = hold_pos_reg;
        cnt_wdata = sat_sum;
        pos_sel   = hold_pos_reg;
        out_next  = '0;
        unique case (in_reg.kind)
            KIND_ADD: begin
                if (found_reg) begin
                    cnt_we             = cmd.finish;
                    out_next.status    = ST_HIT;
                    out_next.entry_key = hold_key_reg;
                    out_next.frequency = sat_sum;
                end else if (!full) begin
                    // append at the end of the table
                    key_we             = cmd.finish;
                    cnt_we             = cmd.finish;
                    wr_addr            = used_reg[AW-1:0];
                    cnt_wdata          = in_reg.amount;
                    pos_sel            = used_reg[AW-1:0];
                    used_next          = used_reg + 1'b1;
                    out_next.status    = ST_NEW;
                    out_next.entry_key = in_reg.key;
                    out_next.frequency = in_reg.amount;
                end else begin
                    out_next.status = ST_FULL;
                end
            end
            KIND_FIND, KIND_READ: begin
                if (found_reg) begin
                    out_next.status    = ST_HIT;
                    out_next.entry_key = hold_key_reg;
                    out_next.frequency = hold_cnt_reg;
                end else begin
                    out_next.status = ST_NONE;
                end
            end
            default: begin
                used_next       = '0;
                out_next.status = ST_HIT;
            end
        endcase
        pos_ext  = 32'(pos_sel);
        fill_ext = 32'(used_next);
        if ((in_reg.kind == KIND_ADD && (found_reg || !full)) ||
            ((in_reg.kind == KIND_FIND || in_reg.kind == KIND_READ) && found_reg)) begin
            out_next.position = pos_ext[7:0];
        end
        out_next.fill_count = fill_ext[8:0];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            used_reg    <= '0;
            rdv_reg     <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_in) begin
                ptr_reg   <= '0;
                rdv_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                if (ptr_in_range) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                rdv_reg <= ptr_in_range;
                if (key_match) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.rd_issue) begin
                rdv_reg <= idx_ok;
            end
            if (cmd.rd_latch && rdv_reg) begin
                found_reg <= 1'b1;
            end
            if (cmd.finish) begin
                used_reg <= used_next;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (rd_en) begin
            rd_addr_reg <= rd_addr;
        end
        if ((cmd.scan_step && key_match) || cmd.rd_latch) begin
            hold_pos_reg <= rd_addr_reg;
            hold_key_reg <= rd_key_reg;
            hold_cnt_reg <= rd_cnt_reg;
        end
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    // key and count memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= in_reg.key;
        end
        if (cnt_we) begin
            cnt_mem[wr_addr] <= cnt_wdata;
        end
        if (rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
        end
    end

endmodule

### rtl/core/bigram_frequency_table.sv
// Each word is accepted in the idle state; clear goes straight to finish, read
// passes the read-issue and read-latch states, and add and find scan the filled
// entries, stopping early on a hit. Throughput: one word at a time; the scan
// reads one table entry per cycle through the single read port of the memories.
// A new word is accepted while the previous result waits in the output register.
// Reset empties the table at once (fill count 0); no clearing pass.
// ----------------------------------------------------------------------------
// Bigram frequency table
// Associative table of 16-bit keys with saturating 32-bit counts: add,
// find, indexed read and clear.
// ----------------------------------------------------------------------------
module bigram_frequency_table #(
    parameter int ENTRIES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bft_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bft_pkg::out_word_t m_data
);
    import bft_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    bft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bft_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

### tb/freq_check_pkg.sv
// ----------------------------------------------------------------------------
// Bigram frequency table scoreboard
// Shadow copy of the key/count table, one expected result word per accepted
// input word, and in-order comparison of the result words field by field.
// ----------------------------------------------------------------------------
package freq_check_pkg;

    import bft_pkg::*;

    class freq_scoreboard;
        int unsigned  depth;
        logic [15:0]  key_at [];
        logic [31:0]  freq_at [];
        int unsigned  used;
        out_word_t    expected_q [$];
        int unsigned  errors;

        function new(int unsigned n);
            depth   = n;
            key_at  = new[n];
            freq_at = new[n];
            used    = 0;
            errors  = 0;
        endfunction

        function int position_of(logic [15:0] k);
            for (int i = 0; i < used; i++) begin
                if (key_at[i] == k) return i;
            end
            return -1;
        endfunction

        // Update the shadow table and queue the result this word must produce.
        function void note_input(in_word_t w);
            out_word_t   r;
            int          pos;
            logic [32:0] sum;
            r = '0;
            case (w.kind)
                KIND_ADD: begin
                    pos = position_of(w.key);
                    if (pos >= 0) begin
                        sum = {1'b0, freq_at[pos]} + {1'b0, w.amount};
                        freq_at[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        r.status    = ST_HIT;
                        r.position  = 8'(pos);
                        r.entry_key = w.key;
                        r.frequency = freq_at[pos];
                    end else if (used < depth) begin
                        key_at[used]  = w.key;
                        freq_at[used] = w.amount;
                        r.status      = ST_NEW;
                        r.position    = 8'(used);
                        r.entry_key   = w.key;
                        r.frequency   = w.amount;
                        used++;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                KIND_FIND: begin
                    pos = position_of(w.key);
                    if (pos >= 0) begin
                        r.status    = ST_HIT;
                        r.position  = 8'(pos);
                        r.entry_key = key_at[pos];
                        r.frequency = freq_at[pos];
                    end else begin
                        r.status = ST_NONE;
                    end
                end
                KIND_READ: begin
                    if (w.index < used) begin
                        r.status    = ST_HIT;
                        r.position  = w.index;
                        r.entry_key = key_at[w.index];
                        r.frequency = freq_at[w.index];
                    end else begin
                        r.status = ST_NONE;
                    end
                end
                KIND_CLEAR: used = 0;
            endcase
            r.fill_count = 9'(used);
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0) begin
                report("unexpected word, status", 32'(got.status), 32'(ST_NONE));
                return;
            end
            want = expected_q.pop_front();
            if (got.status != want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.position != want.position)
                report("position", 32'(got.position), 32'(want.position));
            if (got.entry_key != want.entry_key)
                report("entry_key", 32'(got.entry_key), 32'(want.entry_key));
            if (got.frequency != want.frequency)
                report("frequency", got.frequency, want.frequency);
            if (got.fill_count != want.fill_count)
                report("fill_count", 32'(got.fill_count), 32'(want.fill_count));
        endtask
    endclass

endpackage

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Bigram frequency table testbench
// Directed words for empty, saturating, index-zero and clear cases, then
// random episodes of pooled-key traffic and full-table fills, under several
// source gap and sink stall patterns, checked against a shadow table.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bft_pkg::*;
    import freq_check_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int TOTAL_WORDS = 1350;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int unsigned    src_gap_pct    = 0;
    int unsigned    sink_stall_pct = 0;
    int unsigned    words_sent     = 0;
    freq_scoreboard sb             = new(TABLE_DEPTH);

    bigram_frequency_table #(
        .ENTRIES (TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    function automatic logic [31:0] random_amount();
        case ($urandom_range(3))
            0: return 32'($urandom_range(255));
            1: return $urandom;
            2: return 32'hFFFF_FF00 | 32'($urandom_range(255));
            default: return 32'($urandom_range(65535));
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the handshake.
    task automatic send_word(logic [1:0] kind, logic [15:0] key, logic [31:0] amount,
                             logic [7:0] index);
        in_word_t w;
        w = '{kind: kind, key: key, amount: amount, index: index};
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(w);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic run_directed();
        send_word(KIND_READ,  16'hFFFF, 32'hFFFF_FFFF, 8'h00);
        send_word(KIND_FIND,  16'h0000, 32'h0000_0000, 8'hFF);
        send_word(KIND_ADD,   16'h0000, 32'h0000_0000, 8'h00);
        send_word(KIND_READ,  16'h0000, 32'h0000_0000, 8'h00);
        send_word(KIND_ADD,   16'hFFFF, 32'hFFFF_FFF0, 8'hFF);
        // push past the top of the count, then again from the top
        send_word(KIND_ADD,   16'hFFFF, 32'h0000_0020, 8'h00);
        send_word(KIND_ADD,   16'hFFFF, 32'hFFFF_FFFF, 8'h00);
        send_word(KIND_ADD,   16'h0000, 32'hFFFF_FFFF, 8'h00);
        send_word(KIND_FIND,  16'hFFFF, 32'h0000_0000, 8'h00);
        send_word(KIND_FIND,  16'h1234, 32'hFFFF_FFFF, 8'h00);
        send_word(KIND_READ,  16'h0000, 32'h0000_0000, 8'h01);
        send_word(KIND_READ,  16'h0000, 32'h0000_0000, 8'h02);
        send_word(KIND_READ,  16'hFFFF, 32'h0000_0000, 8'hFF);
        send_word(KIND_ADD,   16'h6162, 32'h0000_0001, 8'hAA);
        send_word(KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_word(KIND_READ,  16'h0000, 32'h0000_0000, 8'h00);
        send_word(KIND_FIND,  16'hFFFF, 32'h0000_0000, 8'h00);
        send_word(KIND_ADD,   16'hFFFF, 32'h0000_0005, 8'h55);
        send_word(KIND_CLEAR, 16'h0000, 32'h0000_0000, 8'h00);
    endtask

    // Mostly a small key pool so adds merge often; some fresh keys and noise.
    task automatic run_mixed(int unsigned n_words);
        logic [15:0] pool [12];
        int unsigned pick;
        foreach (pool[i]) pool[i] = 16'($urandom);
        repeat (n_words) begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_word(KIND_ADD, pool[$urandom_range(11)], random_amount(), 8'($urandom));
            else if (pick < 55)
                send_word(KIND_ADD, 16'($urandom), random_amount(), 8'($urandom));
            else if (pick < 70)
                send_word(KIND_FIND, pool[$urandom_range(11)], $urandom, 8'($urandom));
            else if (pick < 75)
                send_word(KIND_FIND, 16'($urandom), $urandom, 8'($urandom));
            else if (pick < 90)
                send_word(KIND_READ, 16'($urandom), $urandom,
                          (sb.used == 0) ? 8'h00 : 8'($urandom_range(sb.used - 1)));
            else if (pick < 97)
                send_word(KIND_READ, 16'($urandom), $urandom, 8'($urandom));
            else
                send_word(KIND_CLEAR, 16'($urandom), $urandom, 8'($urandom));
        end
    endtask

    // Fill every entry with distinct keys, then probe the full table.
    task automatic run_fill();
        logic [7:0] hi_seed;
        hi_seed = 8'($urandom);
        send_word(KIND_CLEAR, 16'($urandom), $urandom, 8'($urandom));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_word(KIND_ADD, {hi_seed ^ 8'(i * 7), 8'(i)}, random_amount(), 8'($urandom));
        end
        send_word(KIND_ADD, {~hi_seed, 8'h00}, random_amount(), 8'h00);
        send_word(KIND_READ, 16'($urandom), $urandom, 8'hFF);
        repeat (40) begin
            case ($urandom_range(3))
                0: send_word(KIND_ADD, 16'($urandom), random_amount(), 8'($urandom));
                1: send_word(KIND_ADD, sb.key_at[$urandom_range(TABLE_DEPTH - 1)],
                             random_amount(), 8'($urandom));
                2: send_word(KIND_FIND, sb.key_at[$urandom_range(TABLE_DEPTH - 1)],
                             $urandom, 8'($urandom));
                default: send_word(KIND_READ, 16'($urandom), $urandom, 8'($urandom));
            endcase
        end
    endtask

    initial begin
        int unsigned episode;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_directed();
        episode = 0;
        while (words_sent < TOTAL_WORDS) begin
            case (episode % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 76; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 76; end
                default: begin src_gap_pct = 11; sink_stall_pct = 11; end
            endcase
            if (episode == 2 || episode == 9) begin
                run_fill();
            end else begin
                if ($urandom_range(9) < 7)
                    send_word(KIND_CLEAR, 16'($urandom), $urandom, 8'($urandom));
                run_mixed($urandom_range(20, 80));
            end
            episode++;
        end
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        // hold for a full scan so late extra words still show up
        repeat (TABLE_DEPTH + 8) @(posedge aclk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
